/* hdl/oams_pkg.sv */
package oams_pkg;

	localparam logic [15:0] PAGE_MASK = 16'hFF00;

	typedef enum logic [2:0] {
		STEP_IDLE   = 3'd0,
		STEP_DATA   = 3'd1,
		STEP_PTR_LO = 3'd2,
		STEP_PTR_HI = 3'd3
	} step_t;

	typedef enum logic [3:0] {
		AM_IMPL = 4'd0,
		AM_IMM  = 4'd1,
		AM_ZP   = 4'd2,
		AM_ZPX  = 4'd3,
		AM_ZPY  = 4'd4,
		AM_REL  = 4'd5,
		AM_ABS  = 4'd6,
		AM_ABSX = 4'd7,
		AM_ABSY = 4'd8,
		AM_IND  = 4'd9,
		AM_INDX = 4'd10,
		AM_INDY = 4'd11,
		AM_ACC  = 4'd12
	} addr_mode_t;

	typedef enum logic {
		ITEM_START = 1'b0,
		ITEM_REPLY = 1'b1
	} item_t;

	typedef enum logic {
		KIND_READ  = 1'b0,
		KIND_FINAL = 1'b1
	} kind_t;

	typedef struct packed {
		step_t       step;
		addr_mode_t  pending_mode;
		logic [15:0] next_read_address;
		logic [7:0]  low_byte_hold;
		logic [7:0]  saved_index;
		logic [15:0] pointer_hold;
	} seq_state_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] address;
		logic [15:0] data;
		logic        page_crossed;
	} result_t;

endpackage

/* hdl/oams_step.sv */
module oams_step
	import oams_pkg::*;
(
	input  seq_state_t  cur,
	input  logic        mode,
	input  logic [3:0]  addr_mode,
	input  logic [15:0] operand,
	input  logic [7:0]  acc_value,
	input  logic [7:0]  index_x,
	input  logic [7:0]  index_y,
	input  logic [7:0]  read_data,
	output seq_state_t  nxt,
	output logic        emit,
	output result_t     res
);

	logic [7:0]  lo;
	logic [15:0] lo_ext;
	logic [15:0] word;
	logic [15:0] zp_x;
	logic [15:0] zp_y;

	assign lo     = operand[7:0];
	assign lo_ext = {8'h00, lo};
	assign word   = {read_data, cur.low_byte_hold};
	assign zp_x   = {8'h00, 8'(lo + index_x)};
	assign zp_y   = {8'h00, 8'(lo + index_y)};

	always_comb begin
		nxt  = cur;
		emit = 1'b0;
		res  = '{kind: KIND_READ, address: 16'h0000, data: 16'h0000, page_crossed: 1'b0};
		if (item_t'(mode) == ITEM_START) begin
			nxt.step         = STEP_IDLE;
			nxt.pending_mode = addr_mode_t'(addr_mode);
			emit             = 1'b1;
			case (addr_mode_t'(addr_mode))
				AM_IMPL, AM_ACC: begin
					res.kind = KIND_FINAL;
					res.data = {8'h00, acc_value};
				end
				AM_IMM: begin
					res.kind = KIND_FINAL;
					res.data = lo_ext;
				end
				AM_REL: begin
					res.kind    = KIND_FINAL;
					res.address = lo[7] ? (PAGE_MASK | lo_ext) : lo_ext;
				end
				AM_ZP: begin
					nxt.pointer_hold      = lo_ext;
					nxt.next_read_address = lo_ext;
					nxt.step              = STEP_DATA;
					res.address           = lo_ext;
				end
				AM_ZPX: begin
					nxt.pointer_hold      = zp_x;
					nxt.next_read_address = zp_x;
					nxt.step              = STEP_DATA;
					res.address           = zp_x;
				end
				AM_ZPY: begin
					nxt.pointer_hold      = zp_y;
					nxt.next_read_address = zp_y;
					nxt.step              = STEP_DATA;
					res.address           = zp_y;
				end
				AM_ABS: begin
					nxt.pointer_hold      = operand;
					nxt.next_read_address = operand;
					nxt.step              = STEP_DATA;
					res.address           = operand;
				end
				AM_ABSX: begin
					nxt.pointer_hold      = operand;
					nxt.next_read_address = operand + {8'h00, index_x};
					nxt.step              = STEP_DATA;
					res.address           = operand + {8'h00, index_x};
				end
				AM_ABSY: begin
					nxt.pointer_hold      = operand;
					nxt.next_read_address = operand + {8'h00, index_y};
					nxt.step              = STEP_DATA;
					res.address           = operand + {8'h00, index_y};
				end
				AM_IND: begin
					nxt.pointer_hold      = operand;
					nxt.next_read_address = operand;
					nxt.step              = STEP_PTR_LO;
					res.address           = operand;
				end
				AM_INDX: begin
					nxt.pointer_hold      = zp_x;
					nxt.next_read_address = zp_x;
					nxt.step              = STEP_PTR_LO;
					res.address           = zp_x;
				end
				AM_INDY: begin
					nxt.saved_index       = index_y;
					nxt.pointer_hold      = lo_ext;
					nxt.next_read_address = lo_ext;
					nxt.step              = STEP_PTR_LO;
					res.address           = lo_ext;
				end
				default: begin
					res.kind = KIND_FINAL;
				end
			endcase
		end else begin
			case (cur.step)
				STEP_DATA: begin
					nxt.step         = STEP_IDLE;
					emit             = 1'b1;
					res.kind         = KIND_FINAL;
					res.address      = cur.next_read_address;
					res.data         = {8'h00, read_data};
					res.page_crossed = (cur.pointer_hold & PAGE_MASK)
						!= (cur.next_read_address & PAGE_MASK);
				end
				STEP_PTR_LO: begin
					nxt.low_byte_hold     = read_data;
					nxt.next_read_address = cur.next_read_address + 16'd1;
					nxt.step              = STEP_PTR_HI;
					emit                  = 1'b1;
					res.address           = cur.next_read_address + 16'd1;
				end
				STEP_PTR_HI: begin
					emit = 1'b1;
					if (cur.pending_mode == AM_IND) begin
						nxt.step    = STEP_IDLE;
						res.kind    = KIND_FINAL;
						res.address = cur.pointer_hold;
						res.data    = word;
					end else if (cur.pending_mode == AM_INDY) begin
						nxt.pointer_hold      = word;
						nxt.next_read_address = word + {8'h00, cur.saved_index};
						nxt.step              = STEP_DATA;
						res.address           = word + {8'h00, cur.saved_index};
					end else begin
						nxt.pointer_hold      = word;
						nxt.next_read_address = word;
						nxt.step              = STEP_DATA;
						res.address           = word;
					end
				end
				default: begin
					nxt.step = STEP_IDLE;
				end
			endcase
		end
	end

endmodule

/* hdl/operand_address_mode_sequencer_unit.sv */
// Operand addressing-mode sequencer for an 8-bit CPU core.
// Input channel (in_valid/in_ready): a start transfer (mode 0) carries the
// addressing mode, the fetched operand and A, X, Y; a reply transfer (mode 1)
// carries the byte memory returned for the last read request.
// Output channel (out_valid/out_ready): each transfer is either a byte read
// request (kind 0, address) or the final result (kind 1, effective address
// or branch offset, data, page-crossed flag). A mode needing memory emits
// one read request per start or reply until its final result.
// The result of an input transfer is registered in the output register. The
// sequencer takes one input transfer per cycle while in_ready is high; the sequencer state and
// the output register update in the same cycle from short logic.
// A start during a pending sequence drops it; a reply while idle yields no
// output. While the receiver stalls, in_ready stays high only if the output
// register is empty; otherwise the input is held off until the result leaves.
// Reset clears the sequencer to idle and empties the output register.
module operand_address_mode_sequencer_unit
	import oams_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [3:0]  addr_mode,
	input  logic [15:0] operand,
	input  logic [7:0]  acc_value,
	input  logic [7:0]  index_x,
	input  logic [7:0]  index_y,
	input  logic [7:0]  read_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [15:0] address,
	output logic [15:0] data,
	output logic        page_crossed
);

	seq_state_t state_q;
	seq_state_t state_nxt;
	logic       emit;
	result_t    res;
	result_t    res_q;
	logic       out_valid_q;
	logic       accept;

	oams_step u_step (
		.cur       (state_q),
		.mode      (mode),
		.addr_mode (addr_mode),
		.operand   (operand),
		.acc_value (acc_value),
		.index_x   (index_x),
		.index_y   (index_y),
		.read_data (read_data),
		.nxt       (state_nxt),
		.emit      (emit),
		.res       (res)
	);

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{step: STEP_IDLE, pending_mode: AM_IMPL, next_read_address: 16'h0000,
				low_byte_hold: 8'h00, saved_index: 8'h00, pointer_hold: 16'h0000};
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= state_nxt;
			end
			if (accept && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = res_q.kind;
	assign address      = res_q.address;
	assign data         = res_q.data;
	assign page_crossed = res_q.page_crossed;

endmodule

/* tb/operand_address_mode_sequencer_unit_tb.sv */
module operand_address_mode_sequencer_unit_tb
	import oams_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] AM_UNUSED_LO = 4'd13;
	localparam logic [3:0] AM_UNUSED_HI = 4'd15;
	localparam int N_DIRECTED = 31;
	localparam int RESULT_TARGET = 420;

	typedef enum logic [1:0] {
		CHK_MODEL = 2'd0,
		CHK_NONE  = 2'd1,
		CHK_FIXED = 2'd2
	} check_t;

	typedef struct packed {
		item_t       mode;
		logic [3:0]  am;
		logic [15:0] op;
		logic [7:0]  acc;
		logic [7:0]  ix;
		logic [7:0]  iy;
		logic [7:0]  rd;
		check_t      chk;
		kind_t       fk;
		logic [15:0] fa;
		logic [15:0] fd;
		logic        fp;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        mode = 1'b0;
	logic [3:0]  addr_mode = 4'h0;
	logic [15:0] operand = 16'h0;
	logic [7:0]  acc_value = 8'h0;
	logic [7:0]  index_x = 8'h0;
	logic [7:0]  index_y = 8'h0;
	logic [7:0]  read_data = 8'h0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [15:0] address;
	logic [15:0] data;
	logic        page_crossed;

	step_t       seq_step = STEP_IDLE;
	logic [3:0]  held_mode = 4'h0;
	logic [15:0] read_addr = 16'h0;
	logic [7:0]  lo_hold = 8'h0;
	logic [7:0]  idx_save = 8'h0;
	logic [15:0] base_addr = 16'h0;

	result_t     predicted_accesses [$];
	int          failures = 0;
	int          resolved_count = 0;
	bit          steady_in = 1'b0;
	bit          steady_out = 1'b0;

	stim_row_t directed_rows [0:N_DIRECTED-1] = '{
		'{ITEM_REPLY, AM_IMPL, 16'h0000, 8'h00, 8'h00, 8'h00, 8'hA5,
			CHK_NONE, KIND_READ, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_START, AM_IMPL, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			CHK_FIXED, KIND_FINAL, 16'h0000, 16'h00FF, 1'b0},
		'{ITEM_START, AM_ACC, 16'hFFFF, 8'h00, 8'hFF, 8'hFF, 8'hFF,
			CHK_FIXED, KIND_FINAL, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_START, AM_IMM, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00,
			CHK_FIXED, KIND_FINAL, 16'h0000, 16'h00FF, 1'b0},
		'{ITEM_START, AM_REL, 16'h0080, 8'h00, 8'h00, 8'h00, 8'h00,
			CHK_FIXED, KIND_FINAL, 16'hFF80, 16'h0000, 1'b0},
		'{ITEM_START, AM_REL, 16'hFF7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			CHK_FIXED, KIND_FINAL, 16'h007F, 16'h0000, 1'b0},
		'{ITEM_START, AM_UNUSED_LO, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			CHK_FIXED, KIND_FINAL, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_START, AM_UNUSED_HI, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			CHK_FIXED, KIND_FINAL, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_START, AM_ZP, 16'h12FF, 8'h00, 8'h00, 8'h00, 8'h00,
			CHK_FIXED, KIND_READ, 16'h00FF, 16'h0000, 1'b0},
		'{ITEM_REPLY, AM_IMPL, 16'h0000, 8'h00, 8'h00, 8'h00, 8'hFF,
			CHK_FIXED, KIND_FINAL, 16'h00FF, 16'h00FF, 1'b0},
		'{ITEM_START, AM_ZPX, 16'h00FF, 8'h00, 8'h01, 8'h00, 8'h00,
			CHK_FIXED, KIND_READ, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_REPLY, AM_IMPL, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
			CHK_MODEL, KIND_READ, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_START, AM_ABS, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00,
			CHK_MODEL, KIND_READ, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_START, AM_ZPY, 16'h0080, 8'h00, 8'h00, 8'h80, 8'h00,
			CHK_MODEL, KIND_READ, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_REPLY, AM_IMPL, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h5A,
			CHK_MODEL, KIND_READ, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_START, AM_ABSX, 16'h00FF, 8'h00, 8'h01, 8'h00, 8'h00,
			CHK_MODEL, KIND_READ, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_REPLY, AM_IMPL, 16'h0000, 8'h00, 8'h00, 8'h00, 8'hC3,
			CHK_MODEL, KIND_READ, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_START, AM_ABSY, 16'hFFFF, 8'h00, 8'h00, 8'hFF, 8'h00,
			CHK_MODEL, KIND_READ, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_REPLY, AM_IMPL, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h3C,
			CHK_MODEL, KIND_READ, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_START, AM_IND, 16'h12FF, 8'h00, 8'h00, 8'h00, 8'h00,
			CHK_MODEL, KIND_READ, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_REPLY, AM_IMPL, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h34,
			CHK_MODEL, KIND_READ, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_REPLY, AM_IMPL, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h56,
			CHK_MODEL, KIND_READ, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_START, AM_INDX, 16'h00FE, 8'h00, 8'h01, 8'h00, 8'h00,
			CHK_MODEL, KIND_READ, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_REPLY, AM_IMPL, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
			CHK_MODEL, KIND_READ, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_REPLY, AM_IMPL, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h80,
			CHK_MODEL, KIND_READ, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_REPLY, AM_IMPL, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h99,
			CHK_MODEL, KIND_READ, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_START, AM_INDY, 16'h00FF, 8'h00, 8'h00, 8'hFF, 8'h00,
			CHK_MODEL, KIND_READ, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_REPLY, AM_IMPL, 16'h0000, 8'h00, 8'h00, 8'h00, 8'hFF,
			CHK_MODEL, KIND_READ, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_REPLY, AM_IMPL, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
			CHK_MODEL, KIND_READ, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_REPLY, AM_IMPL, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h77,
			CHK_MODEL, KIND_READ, 16'h0000, 16'h0000, 1'b0},
		'{ITEM_REPLY, AM_IMPL, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h11,
			CHK_NONE, KIND_READ, 16'h0000, 16'h0000, 1'b0}
	};

	operand_address_mode_sequencer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.addr_mode    (addr_mode),
		.operand      (operand),
		.acc_value    (acc_value),
		.index_x      (index_x),
		.index_y      (index_y),
		.read_data    (read_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.address      (address),
		.data         (data),
		.page_crossed (page_crossed)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic result_t issue_read(input logic [15:0] addr, input step_t nxt);
		read_addr = addr;
		seq_step = nxt;
		return '{KIND_READ, addr, 16'h0000, 1'b0};
	endfunction

	function automatic void resolve_operand(input stim_row_t r, output bit has,
			output result_t res);
		logic [7:0]  lo;
		logic [15:0] word;
		lo = r.op[7:0];
		has = 1'b1;
		res = '{KIND_FINAL, 16'h0000, 16'h0000, 1'b0};
		if (r.mode == ITEM_START) begin
			seq_step = STEP_IDLE;
			held_mode = r.am;
			case (r.am)
				AM_IMPL, AM_ACC: res.data = {8'h00, r.acc};
				AM_IMM: res.data = {8'h00, lo};
				AM_REL: res.address = {{8{lo[7]}}, lo};
				AM_ZP: begin
					base_addr = {8'h00, lo};
					res = issue_read(base_addr, STEP_DATA);
				end
				AM_ZPX: begin
					base_addr = {8'h00, 8'(lo + r.ix)};
					res = issue_read(base_addr, STEP_DATA);
				end
				AM_ZPY: begin
					base_addr = {8'h00, 8'(lo + r.iy)};
					res = issue_read(base_addr, STEP_DATA);
				end
				AM_ABS: begin
					base_addr = r.op;
					res = issue_read(r.op, STEP_DATA);
				end
				AM_ABSX: begin
					base_addr = r.op;
					res = issue_read(16'(r.op + r.ix), STEP_DATA);
				end
				AM_ABSY: begin
					base_addr = r.op;
					res = issue_read(16'(r.op + r.iy), STEP_DATA);
				end
				AM_IND: begin
					base_addr = r.op;
					res = issue_read(r.op, STEP_PTR_LO);
				end
				AM_INDX: begin
					base_addr = {8'h00, 8'(lo + r.ix)};
					res = issue_read(base_addr, STEP_PTR_LO);
				end
				AM_INDY: begin
					idx_save = r.iy;
					base_addr = {8'h00, lo};
					res = issue_read(base_addr, STEP_PTR_LO);
				end
				default: ;
			endcase
		end else begin
			case (seq_step)
				STEP_DATA: begin
					seq_step = STEP_IDLE;
					res = '{KIND_FINAL, read_addr, {8'h00, r.rd},
						base_addr[15:8] != read_addr[15:8]};
				end
				STEP_PTR_LO: begin
					lo_hold = r.rd;
					res = issue_read(16'(read_addr + 16'd1), STEP_PTR_HI);
				end
				STEP_PTR_HI: begin
					word = {r.rd, lo_hold};
					if (held_mode == AM_IND) begin
						seq_step = STEP_IDLE;
						res = '{KIND_FINAL, base_addr, word, 1'b0};
					end else begin
						base_addr = word;
						if (held_mode == AM_INDY)
							res = issue_read(16'(word + idx_save), STEP_DATA);
						else
							res = issue_read(word, STEP_DATA);
					end
				end
				default: begin
					seq_step = STEP_IDLE;
					has = 1'b0;
				end
			endcase
		end
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic stim_row_t random_item(input item_t m, input logic [3:0] am);
		stim_row_t r;
		r = '0;
		r.mode = m;
		r.am = (m == ITEM_START) ? am : 4'($urandom_range(0, 15));
		r.op = {pick_byte(), pick_byte()};
		r.acc = pick_byte();
		r.ix = pick_byte();
		r.iy = pick_byte();
		r.rd = pick_byte();
		r.chk = CHK_MODEL;
		return r;
	endfunction

	task automatic send_item(input stim_row_t r);
		int gap;
		bit has;
		result_t res;
		gap = steady_in ? 0 : $urandom_range(0, 3);
		if ($urandom_range(0, 19) == 0)
			steady_in = !steady_in;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= r.mode;
		addr_mode <= r.am;
		operand <= r.op;
		acc_value <= r.acc;
		index_x <= r.ix;
		index_y <= r.iy;
		read_data <= r.rd;
		do @(posedge clk); while (!in_ready);
		resolve_operand(r, has, res);
		case (r.chk)
			CHK_FIXED: begin
				has = 1'b1;
				res = '{r.fk, r.fa, r.fd, r.fp};
			end
			CHK_NONE: has = 1'b0;
			default: ;
		endcase
		if (has) begin
			predicted_accesses.push_back(res);
			resolved_count++;
		end
	endtask

	initial begin
		int stall;
		result_t want;
		forever begin
			stall = steady_out ? 0 : $urandom_range(0, 3);
			if ($urandom_range(0, 19) == 0)
				steady_out = !steady_out;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(arst_n && out_valid));
			if (predicted_accesses.size() == 0) begin
				$error("unexpected transfer: kind %0h address %0h data %0h page_crossed %0h",
					kind, address, data, page_crossed);
				failures++;
			end else begin
				want = predicted_accesses.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0h, got %0h", want.kind, kind);
					failures++;
				end
				if (address !== want.address) begin
					$error("address: expected %0h, got %0h", want.address, address);
					failures++;
				end
				if (data !== want.data) begin
					$error("data: expected %0h, got %0h", want.data, data);
					failures++;
				end
				if (page_crossed !== want.page_crossed) begin
					$error("page_crossed: expected %0h, got %0h", want.page_crossed,
						page_crossed);
					failures++;
				end
			end
		end
	end

	initial begin
		stim_row_t r;
		logic [3:0] am;
		int replies;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_item(directed_rows[i]);
		while (resolved_count < RESULT_TARGET) begin
			if ($urandom_range(0, 3) == 0)
				am = 4'($urandom_range(0, 15));
			else
				am = 4'($urandom_range(AM_ZP, AM_INDY));
			send_item(random_item(ITEM_START, am));
			case (am)
				AM_ZP, AM_ZPX, AM_ZPY, AM_ABS, AM_ABSX, AM_ABSY: replies = 1;
				AM_IND: replies = 2;
				AM_INDX, AM_INDY: replies = 3;
				default: replies = 0;
			endcase
			// cut a sequence short so the next start aborts it, or add a stray reply
			case ($urandom_range(0, 9))
				0: replies = $urandom_range(0, replies);
				1: replies = replies + 1;
				default: ;
			endcase
			repeat (replies) begin
				r = random_item(ITEM_REPLY, am);
				send_item(r);
			end
		end
		in_valid <= 1'b0;
		while (predicted_accesses.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
